// File: rtl/tlbfl_pkg.sv
// ----------------------------------------------------------------------------
// tlbfl_pkg
// Shared types, widths and codes for the fully associative TLB.
// ----------------------------------------------------------------------------
package tlbfl_pkg;

    // Table geometry and field widths
    localparam int MAX_ENTRIES = 32;
    localparam int SLOT_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = SLOT_W + 1;
    localparam int PID_W       = 16;
    localparam int PAGE_W      = 20;
    localparam int FRAME_W     = 20;
    localparam int STAMP_W     = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES = 1'd1;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Replacement policy codes
    localparam logic POL_FIFO = 1'b0;
    localparam logic POL_LRU  = 1'b1;

    // Entry count after reset
    localparam logic [CFG_DATA_W-1:0] ENTRIES_RESET = 6'd32;

    typedef struct packed {
        logic               op;
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } in_item_t;

    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame_out;
        logic [SLOT_W-1:0]  slot;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic commit;
    } dp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic need_scan;
        logic scan_done;
    } dp_stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_WRITE
    } state_t;

endpackage

// File: rtl/tlb_fifo_lru.sv
// ----------------------------------------------------------------------------
// tlb_fifo_lru
// Fully associative TLB keyed by pid and page, FIFO or LRU replacement.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                  Payload
//  in        input      in_valid / in_ready        in_data   (op, pid, page, frame)
//  out       output     out_valid / out_ready      out_data  (hit, frame_out, slot)
//  cfg       input      cfg_we                     cfg_index, cfg_data
//
//  Lookups and FIFO or fill inserts go through accept, then tag compare
//  and commit. An LRU insert on a full table adds the oldest-entry scan,
//  one stamp per cycle, and a write step before it commits.
//  Reset clears the valid bits, pointer, time counter and fill count at once.
//  A stalled output holds the finished transaction in the compare or write
//  step until the output register drains; no new input is taken meanwhile.
// ----------------------------------------------------------------------------
module tlb_fifo_lru (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  tlbfl_pkg::in_item_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output tlbfl_pkg::out_item_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [tlbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlbfl_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tlbfl_pkg::dp_cmd_t  cmd;
    tlbfl_pkg::dp_stat_t stat;

    tlbfl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    tlbfl_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

// File: rtl/tlbfl_ctrl.sv
// ----------------------------------------------------------------------------
// tlbfl_ctrl
// Sequencer for one transaction at a time: accept, compare, optional LRU
// scan, then commit into the output register.
// ----------------------------------------------------------------------------
module tlbfl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  tlbfl_pkg::dp_stat_t stat,
    output tlbfl_pkg::dp_cmd_t  cmd
);

    tlbfl_pkg::state_t state_reg;
    tlbfl_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    // Output register can take a result when empty or draining
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            tlbfl_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = tlbfl_pkg::S_EXEC;
                end
            end
            tlbfl_pkg::S_EXEC:
            begin
                if (stat.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = tlbfl_pkg::S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = tlbfl_pkg::S_IDLE;
                end
            end
            tlbfl_pkg::S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = tlbfl_pkg::S_WRITE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            tlbfl_pkg::S_WRITE:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = tlbfl_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = tlbfl_pkg::S_IDLE;
            end
        endcase
    end

    // Set on commit, drop once the transaction is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlbfl_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/tlbfl_dp.sv
// ----------------------------------------------------------------------------
// tlbfl_dp
// Entry storage, parallel tag compare, replacement selection, LRU stamp scan,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module tlbfl_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tlbfl_pkg::in_item_t                  in_data,
    output tlbfl_pkg::out_item_t                 out_data,
    input  logic                                 cfg_we,
    input  logic [tlbfl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tlbfl_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  tlbfl_pkg::dp_cmd_t                   cmd,
    output tlbfl_pkg::dp_stat_t                  stat
);

    localparam int N = tlbfl_pkg::MAX_ENTRIES;
    localparam logic [tlbfl_pkg::CNT_W-1:0] SIZE_MAX = tlbfl_pkg::CNT_W'(N);

    // Configuration
    logic                              policy_reg;
    logic [tlbfl_pkg::CFG_DATA_W-1:0]  entries_reg;

    // Transaction key and entry storage
    tlbfl_pkg::in_item_t               key_reg;
    logic [N-1:0]                      valid_reg;
    logic [tlbfl_pkg::PID_W-1:0]       pid_reg   [N];
    logic [tlbfl_pkg::PAGE_W-1:0]      page_reg  [N];
    logic [tlbfl_pkg::FRAME_W-1:0]     frame_reg [N];
    logic [tlbfl_pkg::STAMP_W-1:0]     stamp_reg [N];

    // Replacement and time state
    logic [tlbfl_pkg::SLOT_W-1:0]      fifo_ptr_reg;
    logic [tlbfl_pkg::STAMP_W-1:0]     time_reg;
    logic [tlbfl_pkg::CNT_W-1:0]       fill_reg;

    // LRU scan
    logic [tlbfl_pkg::CNT_W-1:0]       idx_reg;
    logic [tlbfl_pkg::SLOT_W-1:0]      best_reg;
    logic [tlbfl_pkg::STAMP_W-1:0]     best_stamp_reg;
    logic [tlbfl_pkg::STAMP_W-1:0]     scan_stamp;

    tlbfl_pkg::out_item_t              out_reg;
    tlbfl_pkg::out_item_t              out_next;

    logic [tlbfl_pkg::CNT_W-1:0]       size;
    logic [N-1:0]                      match;
    logic                              hit_any;
    logic [tlbfl_pkg::SLOT_W-1:0]      hit_slot;
    logic                              full;
    logic [tlbfl_pkg::SLOT_W-1:0]      fifo_victim;
    logic [tlbfl_pkg::CNT_W-1:0]       fifo_inc;
    logic [tlbfl_pkg::SLOT_W-1:0]      fifo_next;
    logic [tlbfl_pkg::SLOT_W-1:0]      ins_slot;
    logic                              do_insert;
    logic                              do_touch;
    logic [tlbfl_pkg::SLOT_W-1:0]      stamp_addr;

    // Clamp the configured count to the table depth
    assign size = (tlbfl_pkg::CNT_W'(entries_reg) > SIZE_MAX)
                  ? SIZE_MAX : tlbfl_pkg::CNT_W'(entries_reg);
    assign full = (fill_reg >= size);

    // Compare the key against every valid entry
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            match[i] = valid_reg[i] && (pid_reg[i] == key_reg.pid)
                       && (page_reg[i] == key_reg.page);
        end
    end

    // Lowest matching slot wins
    always_comb
    begin
        hit_slot = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                hit_slot = tlbfl_pkg::SLOT_W'(i);
            end
        end
    end
    assign hit_any = |match;

    // Round-robin victim and pointer advance
    assign fifo_victim = (tlbfl_pkg::CNT_W'(fifo_ptr_reg) < size) ? fifo_ptr_reg : '0;
    assign fifo_inc    = tlbfl_pkg::CNT_W'(fifo_victim) + 1'b1;
    assign fifo_next   = (fifo_inc >= size) ? '0 : fifo_inc[tlbfl_pkg::SLOT_W-1:0];

    // Pick the slot an insert writes
    always_comb
    begin
        if (!full)
        begin
            ins_slot = fill_reg[tlbfl_pkg::SLOT_W-1:0];
        end
        else if (policy_reg == tlbfl_pkg::POL_FIFO)
        begin
            ins_slot = fifo_victim;
        end
        else
        begin
            ins_slot = best_reg;
        end
    end

    assign do_insert  = cmd.commit && (size != '0) && (key_reg.op == tlbfl_pkg::OP_INSERT);
    assign do_touch   = cmd.commit && (size != '0) && (key_reg.op == tlbfl_pkg::OP_LOOKUP)
                        && hit_any;
    assign stamp_addr = do_insert ? ins_slot : hit_slot;

    // Status toward the controller
    assign stat.need_scan = (key_reg.op == tlbfl_pkg::OP_INSERT) && (size != '0) && full
                            && (policy_reg == tlbfl_pkg::POL_LRU);
    assign stat.scan_done = (idx_reg >= size);

    // Result of the committed transaction
    always_comb
    begin
        out_next = '0;
        if (do_touch)
        begin
            out_next.hit       = 1'b1;
            out_next.frame_out = frame_reg[hit_slot];
            out_next.slot      = hit_slot;
        end
        else if (do_insert)
        begin
            out_next.slot = ins_slot;
        end
    end

    assign scan_stamp = stamp_reg[idx_reg[tlbfl_pkg::SLOT_W-1:0]];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg  <= tlbfl_pkg::POL_FIFO;
            entries_reg <= tlbfl_pkg::ENTRIES_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tlbfl_pkg::REG_POLICY:  policy_reg  <= cfg_data[0];
                tlbfl_pkg::REG_ENTRIES: entries_reg <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Control state: valid bits, pointer, time and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            fifo_ptr_reg <= '0;
            time_reg     <= '0;
            fill_reg     <= '0;
        end
        else
        begin
            if (do_insert)
            begin
                valid_reg[ins_slot] <= 1'b1;
                if (!full)
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else if (policy_reg == tlbfl_pkg::POL_FIFO)
                begin
                    fifo_ptr_reg <= fifo_next;
                end
            end
            if (do_insert || do_touch)
            begin
                time_reg <= time_reg + 1'b1;
            end
        end
    end

    // Payload: key, entries, stamps, scan and result
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            key_reg <= in_data;
        end
        if (do_insert)
        begin
            pid_reg[ins_slot]   <= key_reg.pid;
            page_reg[ins_slot]  <= key_reg.page;
            frame_reg[ins_slot] <= key_reg.frame;
        end
        if (do_insert || do_touch)
        begin
            stamp_reg[stamp_addr] <= time_reg;
        end
        if (cmd.scan_start)
        begin
            idx_reg        <= tlbfl_pkg::CNT_W'(1);
            best_reg       <= '0;
            best_stamp_reg <= stamp_reg[0];
        end
        else if (cmd.scan_step)
        begin
            idx_reg <= idx_reg + 1'b1;
            if (scan_stamp < best_stamp_reg)
            begin
                best_reg       <= idx_reg[tlbfl_pkg::SLOT_W-1:0];
                best_stamp_reg <= scan_stamp;
            end
        end
        if (cmd.commit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// File: rtl/tlbfl_checker.sv
// ----------------------------------------------------------------------------
// tlbfl_checker
// Port-level checks for the TLB, bound to the top level.
// ----------------------------------------------------------------------------
module tlbfl_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic                                 in_ready,
    input  logic                                 out_valid,
    input  logic                                 out_ready,
    input  tlbfl_pkg::out_item_t                 out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // A miss or insert reports no frame
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.hit |-> out_data.frame_out == '0)
        else $error("frame reported without a hit");

    // Busy in the cycle after each accepted transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken on back-to-back cycles");

    // A new result follows a busy cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work in flight");

endmodule

bind tlb_fifo_lru tlbfl_checker u_tlbfl_checker (.*);
